### rtl/assert_macros.svh
// Assertion macros for the hash set RTL, used by the back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define CHS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define CHS_ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`else

`define CHS_ASSERT(lbl, prop, msg)

`define CHS_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

### rtl/chs_pkg.sv
// Constants, types and state encodings of the chained hash set.
package chs_pkg;

   localparam int MAX_BUCKETS   = 64;
   localparam int POOL_NODES    = 256;
   localparam int KEY_W         = 16;
   localparam int CNT_W         = 7;
   localparam int BUCKET_W      = $clog2(MAX_BUCKETS);
   localparam int EFF_W         = BUCKET_W + 1;
   localparam int NODE_W        = $clog2(POOL_NODES);
   localparam int LINK_W        = $clog2(POOL_NODES + 1);
   localparam int DIV_RADIX     = 2;
   localparam int DIV_STEPS     = KEY_W / DIV_RADIX;
   localparam int STEP_W        = $clog2(DIV_STEPS);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_IDX_W     = CSR_ADDR_W - 2;

   localparam logic [CNT_W-1:0]     RESET_BUCKETS    = CNT_W'(25);
   localparam logic [LINK_W-1:0]    EMPTY_LINK       = LINK_W'(POOL_NODES);
   localparam logic [CSR_IDX_W-1:0] REG_BUCKET_COUNT = CSR_IDX_W'(0);

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                func;
      logic [KEY_W-1:0]    key;
      logic [BUCKET_W-1:0] bucket;
   } chs_op_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_HEAD,
      BK_DECIDE,
      BK_NODE,
      BK_CMP
   } back_state_type;

endpackage

### rtl/chs_front.sv
// Front end: accepts transactions and works out the bucket of each key.
module chs_front import chs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] bucket_count,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   input  logic [KEY_W-1:0] req_key,
   output chs_op_type       push_op,
   output logic             push_valid,
   input  logic             push_ready
);

   function automatic logic [EFF_W-1:0] eff_buckets(input logic [CNT_W-1:0] bc);
      if (bc == '0) begin
         return EFF_W'(1);
      end
      if (int'(bc) > MAX_BUCKETS) begin
         return EFF_W'(MAX_BUCKETS);
      end
      return EFF_W'(bc);
   endfunction

   function automatic logic [BUCKET_W-1:0] mod_step(input logic [BUCKET_W-1:0] rem,
                                                    input logic [DIV_RADIX-1:0] bits,
                                                    input logic [EFF_W-1:0]     eff);
      logic [EFF_W-1:0]    t;
      logic [BUCKET_W-1:0] r;
      r = rem;
      for (int i = DIV_RADIX - 1; i >= 0; i--) begin
         t = {r, bits[i]};
         if (t >= eff) begin
            t = t - eff;
         end
         r = t[BUCKET_W-1:0];
      end
      return r;
   endfunction

   front_state_type     state_ff, state_in;
   logic                func_ff, func_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [KEY_W-1:0]    sh_ff, sh_in;
   logic [BUCKET_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [EFF_W-1:0]    eff;

   assign eff = eff_buckets(bucket_count);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      key_ff  <= key_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      step_ff <= step_in;
   end

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      key_in     = key_ff;
      sh_in      = sh_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      req_ready  = 1'b0;
      push_valid = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in  = req_func;
               key_in   = req_key;
               sh_in    = req_key;
               rem_in   = '0;
               step_in  = '0;
               state_in = FR_DIV;
            end
         end
         FR_DIV: begin
            rem_in  = mod_step(rem_ff, sh_ff[KEY_W-1 -: DIV_RADIX], eff);
            sh_in   = sh_ff << DIV_RADIX;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = FR_PUSH;
            end
         end
         FR_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FR_IDLE;
            end
         end
         default: begin
            state_in = FR_IDLE;
         end
      endcase
   end

   assign push_op = '{func: func_ff, key: key_ff, bucket: rem_ff};

endmodule

### rtl/chs_queue.sv
// Short queue of classified operations between the front and back ends.
module chs_queue import chs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  chs_op_type wr_op,
   input  logic       wr_valid,
   output logic       wr_ready,
   output chs_op_type rd_op,
   output logic       rd_valid,
   input  logic       rd_ready
);

   chs_op_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_wr;
   logic               do_rd;

   assign wr_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_op    = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      case ({do_wr, do_rd})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_op;
      end
   end

endmodule

### rtl/chs_back.sv
// Back end: bucket heads, node pool, chain walk and result register.
`include "assert_macros.svh"

module chs_back import chs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  chs_op_type op,
   input  logic       op_valid,
   output logic       op_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_found,
   output logic       rsp_status
);

   back_state_type      state_ff, state_in;
   logic                func_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [BUCKET_W-1:0] bucket_ff;

   logic [NODE_W-1:0]      head_mem [MAX_BUCKETS];
   logic [MAX_BUCKETS-1:0] head_vld_ff;
   logic [NODE_W-1:0]      head_rd_ff;
   logic                   head_rd_vld_ff;
   logic [LINK_W-1:0]      head_link;

   logic [KEY_W-1:0]  node_key_mem  [POOL_NODES];
   logic [LINK_W-1:0] node_next_mem [POOL_NODES];
   logic [KEY_W-1:0]  key_rd_ff;
   logic [LINK_W-1:0] next_rd_ff;

   logic [NODE_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] nodes_used_ff, nodes_used_in;
   logic              pool_full;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_found_ff, rsp_status_ff;
   logic res_set, res_found, res_status;
   logic ins_we;
   logic take_op;

   assign pool_full = (nodes_used_ff == LINK_W'(POOL_NODES));
   assign head_link = head_rd_vld_ff ? LINK_W'(head_rd_ff) : EMPTY_LINK;
   assign op_ready  = (state_ff == BK_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign take_op   = op_valid && op_ready;

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      res_set    = 1'b0;
      res_found  = 1'b0;
      res_status = STATUS_OK;
      ins_we     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (take_op) begin
               state_in = BK_HEAD;
            end
         end
         BK_HEAD: begin
            state_in = BK_DECIDE;
         end
         BK_DECIDE: begin
            if (func_ff == FUNC_INSERT) begin
               res_set  = 1'b1;
               state_in = BK_IDLE;
               if (pool_full) begin
                  res_status = STATUS_FULL;
               end else begin
                  ins_we = 1'b1;
               end
            end else if (head_link == EMPTY_LINK) begin
               res_set  = 1'b1;
               state_in = BK_IDLE;
            end else begin
               cur_in   = head_link[NODE_W-1:0];
               state_in = BK_NODE;
            end
         end
         BK_NODE: begin
            state_in = BK_CMP;
         end
         BK_CMP: begin
            if (key_rd_ff == key_ff) begin
               res_set   = 1'b1;
               res_found = 1'b1;
               state_in  = BK_IDLE;
            end else if (next_rd_ff == EMPTY_LINK) begin
               res_set  = 1'b1;
               state_in = BK_IDLE;
            end else begin
               cur_in   = next_rd_ff[NODE_W-1:0];
               state_in = BK_NODE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      nodes_used_in = nodes_used_ff;
      if (ins_we) begin
         nodes_used_in = nodes_used_ff + LINK_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (res_set) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         nodes_used_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         head_vld_ff   <= '0;
      end else begin
         state_ff      <= state_in;
         nodes_used_ff <= nodes_used_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (ins_we) begin
            head_vld_ff[bucket_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_op) begin
         func_ff   <= op.func;
         key_ff    <= op.key;
         bucket_ff <= op.bucket;
      end
      if (res_set) begin
         rsp_found_ff  <= res_found;
         rsp_status_ff <= res_status;
      end
      cur_ff         <= cur_in;
      head_rd_vld_ff <= head_vld_ff[bucket_ff];
   end

   always_ff @(posedge clock) begin
      if (ins_we) begin
         head_mem[bucket_ff] <= nodes_used_ff[NODE_W-1:0];
      end
      head_rd_ff <= head_mem[bucket_ff];
   end

   always_ff @(posedge clock) begin
      if (ins_we) begin
         node_key_mem[nodes_used_ff[NODE_W-1:0]] <= key_ff;
      end
      key_rd_ff <= node_key_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (ins_we) begin
         node_next_mem[nodes_used_ff[NODE_W-1:0]] <= head_link;
      end
      next_rd_ff <= node_next_mem[cur_ff];
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_status = rsp_status_ff;

   `CHS_ASSERT(a_pool_bound, nodes_used_ff <= LINK_W'(POOL_NODES), "node count beyond pool")
   `CHS_ASSERT(a_pool_stays_full, pool_full |=> pool_full, "full pool lost nodes")
   `CHS_ASSERT(a_result_slot_free, res_set |-> !rsp_valid_ff, "result overwrites pending one")
   `CHS_ASSERT(a_walk_in_pool, state_ff == BK_NODE |-> LINK_W'(cur_ff) < nodes_used_ff, "walk left pool")
   `CHS_ASSERT_NEVER(a_no_write_when_full, ins_we && pool_full, "insert written into full pool")

endmodule

### rtl/chained_hash_set.sv
// Top level of the chained hash set: register port, front end, queue and back end.
// Hash set of 16-bit keys kept by separate chaining over a pool of POOL_NODES nodes and
// MAX_BUCKETS bucket heads; the bucket is the key modulo bucket_count (0 reads as 1, values
// above MAX_BUCKETS as MAX_BUCKETS). Each transaction gives one result: found for a search,
// status 1 for an insert refused by a full pool. The front end takes an item, runs eight
// radix-4 remainder steps of the key by the bucket count and hands it to a two-entry queue,
// waiting while the queue is full; it takes no new item before that. The back end reads the
// bucket head; an insert then finishes while a search walks the chain node by node. The
// sustained rate is the slower of the two. Bucket heads carry valid bits cleared by reset,
// so there is no clearing pass and items are taken as soon as reset is released.
module chained_hash_set import chs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [KEY_W-1:0]      req_key,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_found,
   output logic                  rsp_status,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CNT_W-1:0]     bucket_count_ff, bucket_count_in;
   logic [CSR_IDX_W-1:0] csr_index;
   logic                 csr_write;
   chs_op_type           push_op;
   logic                 push_valid;
   logic                 push_ready;
   chs_op_type           pop_op;
   logic                 pop_valid;
   logic                 pop_ready;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      bucket_count_in = bucket_count_ff;
      csr_prdata      = '0;
      if (csr_index == REG_BUCKET_COUNT) begin
         csr_prdata = CSR_DATA_W'(bucket_count_ff);
         if (csr_write) begin
            bucket_count_in = csr_pwdata[CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= RESET_BUCKETS;
      end else begin
         bucket_count_ff <= bucket_count_in;
      end
   end

   chs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .bucket_count (bucket_count_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_func     (req_func),
      .req_key      (req_key),
      .push_op      (push_op),
      .push_valid   (push_valid),
      .push_ready   (push_ready)
   );

   chs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_op    (push_op),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .rd_op    (pop_op),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready)
   );

   chs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op         (pop_op),
      .op_valid   (pop_valid),
      .op_ready   (pop_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_found  (rsp_found),
      .rsp_status (rsp_status)
   );

endmodule

### dv/chained_hash_set_test.sv
// Self-checking testbench of the chained hash set: directed script, then random traffic.
module chained_hash_set_test;
   import chs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int                   HOLD_OFF_CYCLES = 300;
   localparam int                   ITEMS_PER_STAGE = 122;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED      = CSR_IDX_W'(1);

   typedef struct packed {
      logic                  is_csr;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic                  func;
      logic [KEY_W-1:0]      key;
      logic                  typed;
      logic                  found;
      logic                  status;
   } script_row_type;

   typedef struct packed {
      logic found;
      logic status;
   } hash_result_type;

   localparam script_row_type SCRIPT [0:26] = '{
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'h0000, 1'b1, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'hFFFF, 1'b1, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_INSERT, 16'h0000, 1'b1, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_INSERT, 16'hFFFF, 1'b1, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_INSERT, 16'd25,   1'b1, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_INSERT, 16'd25,   1'b1, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'h0000, 1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'd25,   1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'd50,   1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'hFFFF, 1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'd10,   1'b0, 1'b0, STATUS_OK},
      '{1'b1, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'h0000, 1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_INSERT, 16'd7,    1'b1, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'd7,    1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'hFFFF, 1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'd25,   1'b0, 1'b0, STATUS_OK},
      '{1'b1, REG_BUCKET_COUNT, 32'hFFFF_FFFF, FUNC_SEARCH, 16'h0, 1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_INSERT, 16'd64,   1'b1, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'd64,   1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'h0000, 1'b0, 1'b0, STATUS_OK},
      '{1'b1, REG_UNUSED,       32'h3, FUNC_SEARCH, 16'h0000, 1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'd128,  1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_INSERT, 16'h8000, 1'b1, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'h8000, 1'b0, 1'b0, STATUS_OK},
      '{1'b1, REG_BUCKET_COUNT, 32'd64, FUNC_SEARCH, 16'h0000, 1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'h8000, 1'b0, 1'b0, STATUS_OK},
      '{1'b0, REG_BUCKET_COUNT, 32'h0, FUNC_SEARCH, 16'd1,    1'b0, 1'b0, STATUS_OK}
   };

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic                  req_func    = FUNC_SEARCH;
   logic [KEY_W-1:0]      req_key     = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic                  rsp_found;
   logic                  rsp_status;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow copy of the hash set
   logic [CNT_W-1:0]  shadow_count = RESET_BUCKETS;
   logic [LINK_W-1:0] chain_head [MAX_BUCKETS];
   logic [KEY_W-1:0]  slot_key   [POOL_NODES];
   logic [LINK_W-1:0] slot_link  [POOL_NODES];
   int                slots_taken = 0;
   logic [KEY_W-1:0]  stored_keys [$];

   hash_result_type awaited_results [$];
   int              errors        = 0;
   int              tx_idle_pct   = 16;
   int              rx_idle_pct   = 65;
   logic            hold_off_req  = 1'b0;

   chained_hash_set DUT (.*);

   always #5 clock = ~clock;

   function automatic hash_result_type apply_to_shadow(input logic func,
                                                       input logic [KEY_W-1:0] key);
      hash_result_type   res;
      int                eff;
      int                bucket;
      logic [LINK_W-1:0] cur;
      int                steps;
      res    = '{found: 1'b0, status: STATUS_OK};
      eff    = (shadow_count == 0) ? 1 :
               (int'(shadow_count) > MAX_BUCKETS) ? MAX_BUCKETS : int'(shadow_count);
      bucket = int'(key) % eff;
      if (func == FUNC_INSERT) begin
         if (slots_taken >= POOL_NODES) begin
            res.status = STATUS_FULL;
         end else begin
            slot_key[slots_taken]  = key;
            slot_link[slots_taken] = chain_head[bucket];
            chain_head[bucket]     = LINK_W'(slots_taken);
            slots_taken++;
            stored_keys.push_back(key);
         end
      end else begin
         cur   = chain_head[bucket];
         steps = 0;
         while (int'(cur) < slots_taken && steps < slots_taken) begin
            if (slot_key[cur] == key) begin
               res.found = 1'b1;
               break;
            end
            cur = slot_link[cur];
            steps++;
         end
      end
      return res;
   endfunction

   function automatic logic [KEY_W-1:0] pick_key(input bit reuse);
      if (reuse && stored_keys.size() != 0)
         return stored_keys[$urandom_range(stored_keys.size() - 1)];
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2, 3:    return KEY_W'($urandom_range(255));
         default: return KEY_W'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic func, input logic [KEY_W-1:0] key,
                            input logic typed, input hash_result_type typed_res);
      hash_result_type res;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_key   <= key;
      do @(posedge clock); while (!req_ready);
      res = apply_to_shadow(func, key);
      awaited_results.push_back(typed ? typed_res : res);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_BUCKET_COUNT)
         shadow_count = data[CNT_W-1:0];
      // read back the bucket count
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {REG_BUCKET_COUNT, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== CSR_DATA_W'(shadow_count)) begin
         $display("%0t: bucket_count read expected %0d actual %0d",
                  $time, shadow_count, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      hash_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $display("%0t: result with none expected, expected none actual found=%b status=%b",
                     $time, rsp_found, rsp_status);
            errors++;
         end else begin
            want = awaited_results.pop_front();
            if (rsp_found !== want.found) begin
               $display("%0t: found expected %b actual %b", $time, want.found, rsp_found);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %b actual %b", $time, want.status, rsp_status);
               errors++;
            end
         end
      end
   end

   initial begin
      logic [CNT_W-1:0]      cnt;
      logic [CSR_DATA_W-1:0] junk;
      logic                  func;
      logic [KEY_W-1:0]      key;
      int                    insert_pct;
      for (int b = 0; b < MAX_BUCKETS; b++)
         chain_head[b] = EMPTY_LINK;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].is_csr) begin
            drain();
            write_csr(SCRIPT[i].idx, SCRIPT[i].data);
         end else begin
            send_item(SCRIPT[i].func, SCRIPT[i].key, SCRIPT[i].typed,
                      '{found: SCRIPT[i].found, status: SCRIPT[i].status});
         end
      end

      for (int stage = 0; stage < 6; stage++) begin
         case (stage)
            0:       cnt = CNT_W'(MAX_BUCKETS);
            1:       cnt = CNT_W'($urandom_range(2, MAX_BUCKETS - 1));
            2:       cnt = CNT_W'(1);
            3:       cnt = CNT_W'($urandom_range(0, 127));
            4:       cnt = RESET_BUCKETS;
            default: cnt = CNT_W'($urandom_range(MAX_BUCKETS + 1, 127));
         endcase
         tx_idle_pct = (stage < 2) ? 16 : (stage < 4) ? 65 : 0;
         rx_idle_pct = (stage < 2) ? 65 : (stage < 4) ? 16 : 0;
         insert_pct  = (stage < 4) ? 30 : 60;
         junk = $urandom;
         drain();
         write_csr(REG_BUCKET_COUNT, {junk[CSR_DATA_W-1:CNT_W], cnt});
         if (stage == 0 || stage == 4)
            hold_off_req = 1'b1;
         for (int n = 0; n < ITEMS_PER_STAGE; n++) begin
            func = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_SEARCH;
            key  = pick_key((func == FUNC_SEARCH) ? ($urandom_range(99) < 60)
                                                  : ($urandom_range(99) < 15));
            send_item(func, key, 1'b0, '{found: 1'b0, status: STATUS_OK});
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0 && awaited_results.size() == 0)
         $display("chained_hash_set_test passed");
      else
         $display("chained_hash_set_test failed");
      $finish;
   end

   initial begin
      #30_000_000;
      $display("chained_hash_set_test failed");
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/chs_pkg.sv
rtl/chs_front.sv
rtl/chs_queue.sv
rtl/chs_back.sv
rtl/chained_hash_set.sv
dv/chained_hash_set_test.sv
